// ===== sv/vno_pkg.sv =====
// Shared types, constants and saturation helpers for the vector normalise core.
package vno_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COMP_WIDTH = 20;
  localparam int TOL_WIDTH  = 16;
  localparam int LEN2_W     = 2 * COMP_WIDTH;
  localparam int QUOT_W     = COMP_WIDTH + 1;
  localparam int WIDE_W     = LEN2_W + 1;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(66);

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic [COMP_WIDTH-1:0] umag_t;
  typedef comp_t [2:0] vec3_t;

  typedef struct packed {
    logic  req_type;
    comp_t vec_x;
    comp_t vec_y;
    comp_t vec_z;
    comp_t normal_x;
    comp_t normal_y;
    comp_t normal_z;
  } in_word_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    logic  saturated;
  } out_word_t;

  // Sideband that travels with a word through a normalise unit.
  typedef struct packed {
    logic  skip;
    logic  flag;
    logic  req_type;
    vec3_t normal;
  } side_t;

  typedef struct packed {
    logic  sat;
    comp_t val;
  } clamp_t;

  function automatic clamp_t clamp_comp(input logic signed [WIDE_W-1:0] v);
    clamp_t r;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r.sat = 1'b1;
      r.val = hi[COMP_WIDTH-1:0];
    end else if (v < lo) begin
      r.sat = 1'b1;
      r.val = lo[COMP_WIDTH-1:0];
    end else begin
      r.sat = 1'b0;
      r.val = v[COMP_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic umag_t mag_of(input comp_t c);
    comp_t n;
    n = -c;
    return c[COMP_WIDTH-1] ? umag_t'(n) : umag_t'(c);
  endfunction

endpackage

// ===== sv/vno_norm.sv =====
// Pipelined normalise unit: sum of squares, bit-serial square root, per-stage division.
module vno_norm (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [vno_pkg::TOL_WIDTH-1:0]    tol,
  input  logic                             in_vld,
  input  vno_pkg::vec3_t                   in_vec,
  input  vno_pkg::side_t                   in_side,
  output logic                             out_vld,
  output vno_pkg::vec3_t                   out_vec,
  output vno_pkg::side_t                   out_side
);
  import vno_pkg::*;

  localparam int SQ_N  = COMP_WIDTH;
  localparam int DIV_N = QUOT_W;

  // Squares.
  logic                   a_vld_r;
  vec3_t                  a_vec_r;
  side_t                  a_side_r;
  logic [2:0][LEN2_W-1:0] a_sq_r;
  // Sum.
  logic                   b_vld_r;
  vec3_t                  b_vec_r;
  side_t                  b_side_r;
  logic [LEN2_W-1:0]      b_len2_r;

  // Square root pipeline; index 0 holds the pass-through decision.
  logic              s_vld_r  [0:SQ_N];
  vec3_t             s_vec_r  [0:SQ_N];
  side_t             s_side_r [0:SQ_N];
  logic              s_pass_r [0:SQ_N];
  logic [LEN2_W-1:0] s_v_r    [0:SQ_N];
  logic [LEN2_W:0]   s_res_r  [0:SQ_N];

  // Division pipeline; index 0 holds the prepared operands.
  logic                   d_vld_r  [0:DIV_N];
  vec3_t                  d_vec_r  [0:DIV_N];
  side_t                  d_side_r [0:DIV_N];
  logic                   d_pass_r [0:DIV_N];
  umag_t                  d_len_r  [0:DIV_N];
  logic [2:0]             d_ovf_r  [0:DIV_N];
  logic [2:0][COMP_WIDTH-1:0] d_rem_r [0:DIV_N];
  logic [2:0][QUOT_W-1:0] d_num_r  [0:DIV_N];
  logic [2:0][QUOT_W-1:0] d_q_r    [0:DIV_N];

  logic  f_vld_r;
  vec3_t f_vec_r;
  side_t f_side_r;

  logic [2:0][LEN2_W-1:0] a_sq_nxt;
  logic [LEN2_W-1:0]      b_len2_nxt;
  logic [LEN2_W-1:0]      one_c;
  logic [LEN2_W-1:0]      diff_c;
  logic [LEN2_W-1:0]      tol_c;
  logic                   pass_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_sq_nxt[i] = LEN2_W'(mag_of(in_vec[i])) * LEN2_W'(mag_of(in_vec[i]));
    end
    b_len2_nxt = a_sq_r[0] + a_sq_r[1] + a_sq_r[2];
    one_c  = LEN2_W'(1) << (2 * FRAC_BITS);
    diff_c = (b_len2_r > one_c) ? (b_len2_r - one_c) : (one_c - b_len2_r);
    tol_c  = LEN2_W'(tol) << FRAC_BITS;
    pass_nxt = (b_len2_r == '0) || (diff_c <= tol_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r    <= 1'b0;
      b_vld_r    <= 1'b0;
      s_vld_r[0] <= 1'b0;
    end else if (en) begin
      a_vld_r    <= in_vld;
      b_vld_r    <= a_vld_r;
      s_vld_r[0] <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vec_r     <= in_vec;
      a_side_r    <= in_side;
      a_sq_r      <= a_sq_nxt;
      b_vec_r     <= a_vec_r;
      b_side_r    <= a_side_r;
      b_len2_r    <= b_len2_nxt;
      s_vec_r[0]  <= b_vec_r;
      s_side_r[0] <= b_side_r;
      s_pass_r[0] <= pass_nxt;
      s_v_r[0]    <= b_len2_r;
      s_res_r[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
    localparam logic [LEN2_W:0] BIT_C = (LEN2_W+1)'(1) << (2 * (SQ_N - k));
    logic [LEN2_W:0]   trial_c;
    logic [LEN2_W-1:0] v_nxt;
    logic [LEN2_W:0]   res_nxt;
    always_comb begin
      trial_c = s_res_r[k-1] + BIT_C;
      if ({1'b0, s_v_r[k-1]} >= trial_c) begin
        v_nxt   = s_v_r[k-1] - trial_c[LEN2_W-1:0];
        res_nxt = (s_res_r[k-1] >> 1) + BIT_C;
      end else begin
        v_nxt   = s_v_r[k-1];
        res_nxt = s_res_r[k-1] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_vld_r[k] <= 1'b0;
      end else if (en) begin
        s_vld_r[k] <= s_vld_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_vec_r[k]  <= s_vec_r[k-1];
        s_side_r[k] <= s_side_r[k-1];
        s_pass_r[k] <= s_pass_r[k-1];
        s_v_r[k]    <= v_nxt;
        s_res_r[k]  <= res_nxt;
      end
    end
  end

  // Operand preparation: the quotient keeps its low QUOT_W bits, the rest is overflow.
  umag_t                          len_c;
  logic [2:0]                     ovf_c;
  logic [2:0][COMP_WIDTH-1:0]     rem0_c;
  logic [2:0][QUOT_W-1:0]         num0_c;
  logic [COMP_WIDTH+FRAC_BITS-1:0] numw_c;

  always_comb begin
    len_c = (s_res_r[SQ_N][COMP_WIDTH-1:0] == '0) ? umag_t'(1) :
            s_res_r[SQ_N][COMP_WIDTH-1:0];
    numw_c = '0;
    for (int i = 0; i < 3; i++) begin
      numw_c    = {mag_of(s_vec_r[SQ_N][i]), {FRAC_BITS{1'b0}}};
      rem0_c[i] = COMP_WIDTH'(numw_c >> QUOT_W);
      num0_c[i] = numw_c[QUOT_W-1:0];
      ovf_c[i]  = rem0_c[i] >= len_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r[0] <= 1'b0;
    end else if (en) begin
      d_vld_r[0] <= s_vld_r[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_vec_r[0]  <= s_vec_r[SQ_N];
      d_side_r[0] <= s_side_r[SQ_N];
      d_pass_r[0] <= s_pass_r[SQ_N];
      d_len_r[0]  <= len_c;
      d_ovf_r[0]  <= ovf_c;
      d_rem_r[0]  <= rem0_c;
      d_num_r[0]  <= num0_c;
      d_q_r[0]    <= '0;
    end
  end

  for (genvar j = 1; j <= DIV_N; j++) begin : g_div
    logic [2:0][COMP_WIDTH-1:0] rem_nxt;
    logic [2:0][QUOT_W-1:0]     num_nxt;
    logic [2:0][QUOT_W-1:0]     q_nxt;
    logic [COMP_WIDTH:0]        rem2_c [3];
    logic [COMP_WIDTH:0]        sub_c  [3];
    logic                       ge_c   [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem2_c[i]  = {d_rem_r[j-1][i], d_num_r[j-1][i][QUOT_W-1]};
        sub_c[i]   = rem2_c[i] - {1'b0, d_len_r[j-1]};
        ge_c[i]    = rem2_c[i] >= {1'b0, d_len_r[j-1]};
        rem_nxt[i] = ge_c[i] ? sub_c[i][COMP_WIDTH-1:0] : rem2_c[i][COMP_WIDTH-1:0];
        num_nxt[i] = d_num_r[j-1][i] << 1;
        q_nxt[i]   = {d_q_r[j-1][i][QUOT_W-2:0], ge_c[i]};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_vld_r[j] <= 1'b0;
      end else if (en) begin
        d_vld_r[j] <= d_vld_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_vec_r[j]  <= d_vec_r[j-1];
        d_side_r[j] <= d_side_r[j-1];
        d_pass_r[j] <= d_pass_r[j-1];
        d_len_r[j]  <= d_len_r[j-1];
        d_ovf_r[j]  <= d_ovf_r[j-1];
        d_rem_r[j]  <= rem_nxt;
        d_num_r[j]  <= num_nxt;
        d_q_r[j]    <= q_nxt;
      end
    end
  end

  // Sign reapplied, then saturated to the component range.
  vec3_t              f_vec_nxt;
  side_t              f_side_nxt;
  logic [QUOT_W-1:0]  pos_max_c;
  logic [QUOT_W-1:0]  neg_max_c;
  logic [QUOT_W-1:0]  qneg_c;
  logic               neg_c;
  logic               sat_any_c;

  always_comb begin
    pos_max_c  = {2'b00, {(COMP_WIDTH-1){1'b1}}};
    neg_max_c  = {2'b01, {(COMP_WIDTH-1){1'b0}}};
    f_vec_nxt  = d_vec_r[DIV_N];
    f_side_nxt = d_side_r[DIV_N];
    sat_any_c  = 1'b0;
    qneg_c     = '0;
    neg_c      = 1'b0;
    if (!(d_pass_r[DIV_N] || d_side_r[DIV_N].skip)) begin
      for (int i = 0; i < 3; i++) begin
        neg_c  = d_vec_r[DIV_N][i][COMP_WIDTH-1];
        qneg_c = -d_q_r[DIV_N][i];
        if (neg_c) begin
          if (d_ovf_r[DIV_N][i] || d_q_r[DIV_N][i] > neg_max_c) begin
            f_vec_nxt[i] = {1'b1, {(COMP_WIDTH-1){1'b0}}};
            sat_any_c    = 1'b1;
          end else begin
            f_vec_nxt[i] = qneg_c[COMP_WIDTH-1:0];
          end
        end else begin
          if (d_ovf_r[DIV_N][i] || d_q_r[DIV_N][i] > pos_max_c) begin
            f_vec_nxt[i] = {1'b0, {(COMP_WIDTH-1){1'b1}}};
            sat_any_c    = 1'b1;
          end else begin
            f_vec_nxt[i] = d_q_r[DIV_N][i][COMP_WIDTH-1:0];
          end
        end
      end
      f_side_nxt.flag = d_side_r[DIV_N].flag | sat_any_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= d_vld_r[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_vec_r  <= f_vec_nxt;
      f_side_r <= f_side_nxt;
    end
  end

  assign out_vld  = f_vld_r;
  assign out_vec  = f_vec_r;
  assign out_side = f_side_r;

endmodule

// ===== sv/vector3_normalize_orthonormalize_core.sv =====
// Throughput: one word per cycle while the output is not stalled; every stage is registered.
// A stalled output freezes the whole pipeline in place; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears every valid bit and sets the tolerance register to 66.
// Payload registers are not reset.
// Top level: normalise or Gram-Schmidt orthonormalise one 3D Q3.16 vector per word.
module vector3_normalize_orthonormalize_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  vno_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output vno_pkg::out_word_t             out_data,
  input  logic                           cfg_we,
  input  logic [vno_pkg::TOL_WIDTH-1:0]  cfg_data
);
  import vno_pkg::*;

  // The tolerance register is to be written only while the pipeline is empty, so that
  // every stage may read it directly; the block itself does not enforce this.
  logic [TOL_WIDTH-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_data;
    end
  end

  // One global advance signal: the pipeline moves unless a finished word is held
  // at the output by the consumer.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  vec3_t u1_in_vec;
  side_t u1_in_side;
  logic  u1_vld;
  vec3_t u1_vec;
  side_t u1_side;

  always_comb begin
    u1_in_vec[0]          = in_data.vec_x;
    u1_in_vec[1]          = in_data.vec_y;
    u1_in_vec[2]          = in_data.vec_z;
    u1_in_side.normal[0]  = in_data.normal_x;
    u1_in_side.normal[1]  = in_data.normal_y;
    u1_in_side.normal[2]  = in_data.normal_z;
    u1_in_side.req_type   = in_data.req_type;
    u1_in_side.flag       = 1'b0;
    u1_in_side.skip       = 1'b0;
  end

  // First unit: the input vector (or tangent) is normalised.
  vno_norm u_norm1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .tol      (tol_r),
    .in_vld   (in_valid),
    .in_vec   (u1_in_vec),
    .in_side  (u1_in_side),
    .out_vld  (u1_vld),
    .out_vec  (u1_vec),
    .out_side (u1_side)
  );

  // Projection removal over four stages: n*t products, dot sum, n*dot products,
  // difference. Normalise requests travel through untouched.
  logic                     t1_vld_r, t2_vld_r, t3_vld_r, t4_vld_r;
  vec3_t                    t1_vec_r, t2_vec_r, t3_vec_r, t4_vec_r;
  side_t                    t1_side_r, t2_side_r, t3_side_r, t4_side_r;
  logic signed [LEN2_W-1:0] t1_p_r [3];
  comp_t                    t2_d_r;
  logic signed [LEN2_W-1:0] t3_p_r [3];

  logic signed [WIDE_W-1:0] dsum_c;
  clamp_t                   dclamp_c;
  side_t                    t2_side_nxt;
  clamp_t                   dif_c [3];
  logic signed [WIDE_W-1:0] dif_w_c [3];
  vec3_t                    t4_vec_nxt;
  side_t                    t4_side_nxt;

  always_comb begin
    // An arithmetic shift is the floor of the division by 2^FRAC_BITS.
    dsum_c = '0;
    for (int i = 0; i < 3; i++) begin
      dsum_c = dsum_c + WIDE_W'(t1_p_r[i] >>> FRAC_BITS);
    end
    dclamp_c         = clamp_comp(dsum_c);
    t2_side_nxt      = t1_side_r;
    t2_side_nxt.flag = t1_side_r.flag | (t1_side_r.req_type & dclamp_c.sat);
  end

  always_comb begin
    t4_vec_nxt  = t3_vec_r;
    t4_side_nxt = t3_side_r;
    for (int i = 0; i < 3; i++) begin
      dif_w_c[i] = WIDE_W'(t3_vec_r[i]) - WIDE_W'(t3_p_r[i] >>> FRAC_BITS);
      dif_c[i]   = clamp_comp(dif_w_c[i]);
    end
    // The second unit passes normalise requests straight through.
    t4_side_nxt.skip = !t3_side_r.req_type;
    if (t3_side_r.req_type) begin
      for (int i = 0; i < 3; i++) begin
        t4_vec_nxt[i] = dif_c[i].val;
      end
      t4_side_nxt.flag = t3_side_r.flag | dif_c[0].sat | dif_c[1].sat | dif_c[2].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
      t4_vld_r <= 1'b0;
    end else if (en) begin
      t1_vld_r <= u1_vld;
      t2_vld_r <= t1_vld_r;
      t3_vld_r <= t2_vld_r;
      t4_vld_r <= t3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_vec_r  <= u1_vec;
      t1_side_r <= u1_side;
      for (int i = 0; i < 3; i++) begin
        t1_p_r[i] <= LEN2_W'($signed(u1_side.normal[i]) * $signed(u1_vec[i]));
      end
      t2_vec_r  <= t1_vec_r;
      t2_side_r <= t2_side_nxt;
      t2_d_r    <= dclamp_c.val;
      t3_vec_r  <= t2_vec_r;
      t3_side_r <= t2_side_r;
      for (int i = 0; i < 3; i++) begin
        t3_p_r[i] <= LEN2_W'($signed(t2_side_r.normal[i]) * $signed(t2_d_r));
      end
      t4_vec_r  <= t4_vec_nxt;
      t4_side_r <= t4_side_nxt;
    end
  end

  // Second unit: the difference vector is normalised again.
  logic  u2_vld;
  vec3_t u2_vec;
  side_t u2_side;

  vno_norm u_norm2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .tol      (tol_r),
    .in_vld   (t4_vld_r),
    .in_vec   (t4_vec_r),
    .in_side  (t4_side_r),
    .out_vld  (u2_vld),
    .out_vec  (u2_vec),
    .out_side (u2_side)
  );

  // The second unit's last stage is the output register.
  assign out_valid          = u2_vld;
  assign out_data.out_x     = u2_vec[0];
  assign out_data.out_y     = u2_vec[1];
  assign out_data.out_z     = u2_vec[2];
  assign out_data.saturated = u2_side.flag;

endmodule

// ===== sv/vno_chk.sv =====
// Port-level checker for the vector normalise core, bound to the top level.
module vno_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input vno_pkg::in_word_t              in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input vno_pkg::out_word_t             out_data
);
  import vno_pkg::*;

  // A held result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A stalled input word is held by the sender until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input word changed while stalled");

  // Input is only held off when a finished word is waiting at the output.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output");

  // Backpressure passes through to the input in the same cycle.
  a_stall_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while the output is blocked");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind vector3_normalize_orthonormalize_core vno_chk u_vno_chk (.*);

// ===== verif/vector3_normalize_orthonormalize_core_tb.sv =====
// Testbench for the vector normalise and orthonormalise core: random and directed words.
`timescale 1ns / 100ps

module vector3_normalize_orthonormalize_core_tb;
  import vno_pkg::*;

  // Request codes carried in req_type.
  localparam logic REQ_NORMALISE = 1'b0;
  localparam logic REQ_ORTHO     = 1'b1;

  localparam longint COMP_MAX = (64'sd1 <<< (COMP_WIDTH - 1)) - 1;
  localparam longint COMP_MIN = -COMP_MAX - 1;
  localparam longint UNIT     = 64'sd1 <<< FRAC_BITS;
  // Settle for a little longer than the latency of the core.
  localparam int SETTLE_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_WORDS  = 1930;

  // Holds the vectors the core should produce, oldest first, and checks results against them.
  class vector_scoreboard;
    out_word_t pending[$];
    logic [TOL_WIDTH-1:0] tolerance;
    int mismatches;

    function new();
      tolerance = TOL_RESET;
      mismatches = 0;
    endfunction

    function longint clamp_val(longint v, inout bit sat);
      if (v > COMP_MAX) begin
        sat = 1;
        return COMP_MAX;
      end
      if (v < COMP_MIN) begin
        sat = 1;
        return COMP_MIN;
      end
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Divides the vector by its length unless it is zero or already close to unit length.
    function void unit_vector(input longint c[3], output longint o[3], inout bit sat);
      longint unsigned len2;
      longint unsigned one;
      longint unsigned diff;
      longint unsigned len;
      longint unsigned m;
      longint unsigned q;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
        m = (c[i] < 0) ? -c[i] : c[i];
        len2 += m * m;
      end
      one = 64'd1 << (2 * FRAC_BITS);
      diff = (len2 > one) ? len2 - one : one - len2;
      if (len2 == 0 || diff <= (longint'(tolerance) << FRAC_BITS)) begin
        o = c;
        return;
      end
      len = int_sqrt(len2);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
        m = (c[i] < 0) ? -c[i] : c[i];
        q = (m << FRAC_BITS) / len;
        o[i] = clamp_val((c[i] < 0) ? -longint'(q) : longint'(q), sat);
      end
    endfunction

    function void note_input(in_word_t w);
      longint v[3];
      longint n[3];
      longint t[3];
      longint r[3];
      longint d;
      longint dv[3];
      bit sat;
      out_word_t res;
      sat = 0;
      v[0] = w.vec_x;
      v[1] = w.vec_y;
      v[2] = w.vec_z;
      n[0] = w.normal_x;
      n[1] = w.normal_y;
      n[2] = w.normal_z;
      if (w.req_type == REQ_NORMALISE) begin
        unit_vector(v, r, sat);
      end else begin
        unit_vector(v, t, sat);
        d = 0;
        for (int i = 0; i < 3; i++) d += (n[i] * t[i]) >>> FRAC_BITS;
        d = clamp_val(d, sat);
        for (int i = 0; i < 3; i++) dv[i] = clamp_val(t[i] - ((n[i] * d) >>> FRAC_BITS), sat);
        unit_vector(dv, r, sat);
      end
      res.out_x = comp_t'(r[0]);
      res.out_y = comp_t'(r[1]);
      res.out_z = comp_t'(r[2]);
      res.saturated = sat;
      pending.push_back(res);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h with nothing pending", got);
        return;
      end
      want = pending.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_z !== want.out_z || got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected (%0d %0d %0d sat %b) got (%0d %0d %0d sat %b)",
                   want.out_x, want.out_y, want.out_z, want.saturated,
                   got.out_x, got.out_y, got.out_z, got.saturated);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [TOL_WIDTH-1:0] cfg_data = '0;

  vector_scoreboard board = new();
  bit no_idle = 0;       // When set, neither side inserts gaps or stalls.
  int quiet_cycles = 0;  // Cycles since the last word moved on either channel.

  vector3_normalize_orthonormalize_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Both channels are sampled at the rising edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // The watchdog ends the run if nothing moves for far longer than any correct run would allow.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiving side stalls for a random number of cycles before taking each result word.
  initial begin
    int k;
    @(posedge clk iff rst_n);
    forever begin
      k = no_idle ? 0 : $urandom_range(0, 8);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one word after a random gap and returns once the core has taken it. Valid is left
  // high so that a following word with no gap goes straight out on the next edge.
  task automatic send_word(in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    board.note_input(w);
  endtask

  // Drains the pipeline, then writes the tolerance register while the core is idle.
  task automatic set_tolerance(logic [TOL_WIDTH-1:0] tol);
    in_valid <= 1'b0;
    wait (board.pending.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= tol;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.tolerance = tol;
  endtask

  function automatic in_word_t make_word(logic req, longint vx, longint vy, longint vz,
                                         longint nx, longint ny, longint nz);
    in_word_t w;
    w.req_type = req;
    w.vec_x = comp_t'(vx);
    w.vec_y = comp_t'(vy);
    w.vec_z = comp_t'(vz);
    w.normal_x = comp_t'(nx);
    w.normal_y = comp_t'(ny);
    w.normal_z = comp_t'(nz);
    return w;
  endfunction

  // A component near unit scale, sometimes tiny, sometimes anywhere in range.
  function automatic longint rand_comp();
    case ($urandom_range(0, 5))
      0: return longint'(comp_t'($urandom));
      1: return $signed($urandom_range(0, 16)) - 8;
      2: return UNIT + $signed($urandom_range(0, 200)) - 100;
      default: return $signed($urandom_range(0, 2 * UNIT)) - UNIT;
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w = make_word(1'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), rand_comp(), rand_comp());
    // Some words sit just around unit length so the tolerance test decides the outcome.
    if ($urandom_range(0, 4) == 0) begin
      w.vec_x = comp_t'(UNIT + $signed($urandom_range(0, 80)) - 40);
      w.vec_y = comp_t'($signed($urandom_range(0, 400)) - 200);
      w.vec_z = '0;
    end
    return w;
  endfunction

  task automatic directed_words();
    // Zero vector, exact unit, tolerance edges and the extremes of the component range.
    send_word(make_word(REQ_NORMALISE, 0, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_NORMALISE, UNIT, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_NORMALISE, 0, -UNIT, 0, 0, 0, 0));
    send_word(make_word(REQ_NORMALISE, UNIT + 1, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_NORMALISE, UNIT + 2000, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_NORMALISE, COMP_MAX, COMP_MAX, COMP_MAX, 0, 0, 0));
    send_word(make_word(REQ_NORMALISE, COMP_MIN, COMP_MIN, COMP_MIN, 0, 0, 0));
    send_word(make_word(REQ_NORMALISE, COMP_MIN, 0, 0, -1, -1, -1));
    send_word(make_word(REQ_NORMALISE, 1, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_NORMALISE, -1, 1, -1, 0, 0, 0));
    send_word(make_word(REQ_NORMALISE, 3, 4, 0, 0, 0, 0));
    // Orthonormalise: perpendicular, parallel (difference collapses to zero) and extremes.
    send_word(make_word(REQ_ORTHO, UNIT, 0, 0, 0, UNIT, 0));
    send_word(make_word(REQ_ORTHO, UNIT, UNIT, 0, 0, 0, UNIT));
    send_word(make_word(REQ_ORTHO, UNIT, 0, 0, UNIT, 0, 0));
    send_word(make_word(REQ_ORTHO, 0, 0, 0, UNIT, UNIT, UNIT));
    send_word(make_word(REQ_ORTHO, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
    send_word(make_word(REQ_ORTHO, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
    send_word(make_word(REQ_ORTHO, UNIT, 2 * UNIT, -UNIT, COMP_MIN, COMP_MAX, COMP_MIN));
    send_word(make_word(REQ_ORTHO, UNIT, 5, 0, UNIT, 0, 0));
    send_word(make_word(REQ_ORTHO, 7, -3, 2, 0, -UNIT, 0));
  endtask

  initial begin
    logic [TOL_WIDTH-1:0] settings[6];
    settings = '{16'd0, 16'hFFFF, 16'd1, 16'd66, 16'd4000, 16'd0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();
    // The last setting is drawn at random; every phase runs a share of the random words.
    settings[5] = TOL_WIDTH'($urandom_range(0, 65535));
    foreach (settings[p]) begin
      set_tolerance(settings[p]);
      if (p == 1) directed_words();
      for (int i = 0; i < RANDOM_WORDS / 6; i++) begin
        if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_word(rand_word());
      end
    end
    in_valid <= 1'b0;
    no_idle = 0;

    wait (board.pending.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/vno_pkg.sv
sv/vno_norm.sv
sv/vector3_normalize_orthonormalize_core.sv
sv/vno_chk.sv
verif/vector3_normalize_orthonormalize_core_tb.sv
